### hdl/ltpc_pkg.sv
// Shared types and constants of the triangle-pulse color cycler.
package ltpc_pkg;

    localparam int unsigned MAX_COLORS = 4;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned REM_W   = 24;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned CFG_W   = 3;
    localparam int unsigned PROD_W  = 17;

    // Register indexes on the configuration port
    localparam logic [CFG_W-1:0] REG_DURATION = 3'd0;
    localparam logic [CFG_W-1:0] REG_COUNT    = 3'd1;
    localparam logic [CFG_W-1:0] REG_COLOR_0  = 3'd2;
    localparam logic [CFG_W-1:0] REG_COLOR_1  = 3'd3;
    localparam logic [CFG_W-1:0] REG_COLOR_2  = 3'd4;
    localparam logic [CFG_W-1:0] REG_COLOR_3  = 3'd5;

    localparam logic [DUR_W-1:0]   DURATION_RST = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_RST    = 3'd1;

    // Channel order while scaling
    localparam logic [CNT_W-1:0] CH_RED   = 3'd0;
    localparam logic [CNT_W-1:0] CH_GREEN = 3'd1;
    localparam logic [CNT_W-1:0] CH_BLUE  = 3'd2;

    localparam logic [CNT_W-1:0] DIV_TOP = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_CHECK,
        ST_PROD,
        ST_DIV,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef enum logic {
        UNIT_SUB,
        UNIT_MUL
    } unit_op_t;

    typedef struct packed {
        unit_op_t          op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              borrow;
        logic [PROD_W-1:0] prod;
    } unit_rsp_t;

endpackage

### hdl/ltpc_unit.sv
// Shared arithmetic unit: 32-bit subtract with borrow, 8x9 multiply.
module ltpc_unit (
    input  ltpc_pkg::unit_req_t req,
    output ltpc_pkg::unit_rsp_t rsp
);

    logic [ltpc_pkg::TIME_W:0] diff_w;

    assign diff_w = {1'b0, req.a} - {1'b0, req.b};

    always_comb begin
        rsp = '0;
        case (req.op)
            ltpc_pkg::UNIT_SUB: begin
                rsp.diff   = diff_w[ltpc_pkg::TIME_W-1:0];
                rsp.borrow = diff_w[ltpc_pkg::TIME_W];
            end
            ltpc_pkg::UNIT_MUL: begin
                rsp.prod = {9'd0, req.a[7:0]} * {8'd0, req.b[8:0]};
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

endmodule

### hdl/led_triangle_pulse_color_cycler.sv
// Top level of the triangle-pulse color cycler: sequencer, state and registers.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_now_ms[31:0]
//  m_        out        m_valid / m_ready    m_out_red, m_out_green, m_out_blue,
//                                            m_color_index[1:0], m_phase[7:0]
//  cfg_      in         cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[23:0]
//
// One shared subtract/multiply unit serves every step from acceptance to the result register:
// elapsed, compare, product, 8 divide steps, 3 scale steps and load when the phase continues;
// elapsed, compare, 3 scale steps and load when it restarts. The next beat is taken in idle.
// s_ready is high only while idle; a held result stalls the sequencer in its load step only
// when the output register is still full. Reset (aresetn low, synchronous) restores the
// register defaults and clears phase start time and color index; cfg_ready is always high.
module led_triangle_pulse_color_cycler (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic [1:0]  m_color_index,
    output logic [7:0]  m_phase,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // Configuration registers
    logic [ltpc_pkg::DUR_W-1:0]   duration_reg;
    logic [ltpc_pkg::COUNT_W-1:0] count_reg;
    logic [ltpc_pkg::COLOR_W-1:0] palette_reg [ltpc_pkg::MAX_COLORS];

    // Sequencer and state
    ltpc_pkg::state_t state_reg, state_next;
    logic [ltpc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ltpc_pkg::TIME_W-1:0] start_reg, start_next;
    logic [ltpc_pkg::IDX_W-1:0]  color_reg, color_next;
    logic                        m_valid_reg, m_valid_next;

    // Working registers (no reset)
    logic [ltpc_pkg::TIME_W-1:0] now_reg, now_next;
    logic [ltpc_pkg::TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [ltpc_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [ltpc_pkg::CHAN_W-1:0] phase_reg, phase_next;
    logic [ltpc_pkg::CHAN_W-1:0] scale_reg [3];
    logic [ltpc_pkg::CHAN_W-1:0] scale_next;
    logic                        scale_we;

    // Output registers
    logic [ltpc_pkg::CHAN_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic [ltpc_pkg::CHAN_W-1:0] out_phase_reg;
    logic [ltpc_pkg::IDX_W-1:0]  out_index_reg;
    logic                        out_load;

    ltpc_pkg::unit_req_t unit_req;
    ltpc_pkg::unit_rsp_t unit_rsp;

    logic [ltpc_pkg::CHAN_W-1:0]  tri_half;
    logic [ltpc_pkg::CHAN_W:0]    weight;
    logic [ltpc_pkg::COLOR_W-1:0] color_sel;
    logic [ltpc_pkg::CHAN_W-1:0]  chan_sel;
    logic [ltpc_pkg::COUNT_W-1:0] limit;
    logic [ltpc_pkg::IDX_W-1:0]   color_inc;

    ltpc_unit u_unit (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    assign s_ready   = (state_reg == ltpc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Triangle weight: fold the upper half, double, then add one
    assign tri_half = phase_reg[7] ? (8'hFF - phase_reg) : phase_reg;
    assign weight   = {1'b0, tri_half[6:0], 1'b0} + 9'd1;

    assign color_sel = palette_reg[color_reg];
    assign limit     = (count_reg > 3'(ltpc_pkg::MAX_COLORS)) ?
                       3'(ltpc_pkg::MAX_COLORS) : count_reg;
    assign color_inc = color_reg + 2'd1;

    always_comb begin
        case (cnt_reg)
            ltpc_pkg::CH_RED:   chan_sel = color_sel[23:16];
            ltpc_pkg::CH_GREEN: chan_sel = color_sel[15:8];
            default:            chan_sel = color_sel[7:0];
        endcase
    end

    // Next state, unit operands and register updates
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        start_next   = start_reg;
        color_next   = color_reg;
        now_next     = now_reg;
        elapsed_next = elapsed_reg;
        rem_next     = rem_reg;
        phase_next   = phase_reg;
        scale_next   = unit_rsp.prod[15:8];
        scale_we     = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        unit_req.op  = ltpc_pkg::UNIT_SUB;
        unit_req.a   = '0;
        unit_req.b   = '0;

        case (state_reg)
            ltpc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    now_next   = s_now_ms;
                    state_next = ltpc_pkg::ST_ELAPSED;
                end
            end
            ltpc_pkg::ST_ELAPSED: begin
                // wrap-safe elapsed time
                unit_req.a   = now_reg;
                unit_req.b   = start_reg;
                elapsed_next = unit_rsp.diff;
                state_next   = ltpc_pkg::ST_CHECK;
            end
            ltpc_pkg::ST_CHECK: begin
                unit_req.a = elapsed_reg;
                unit_req.b = {16'd0, duration_reg};
                if (!unit_rsp.borrow) begin
                    // phase complete: restart and advance the palette
                    phase_next = '0;
                    start_next = now_reg;
                    color_next = ({1'b0, color_inc} >= limit) ? 2'd0 : color_inc;
                    cnt_next   = ltpc_pkg::CH_RED;
                    state_next = ltpc_pkg::ST_SCALE;
                end else begin
                    state_next = ltpc_pkg::ST_PROD;
                end
            end
            ltpc_pkg::ST_PROD: begin
                // elapsed * 255 as (elapsed << 8) - elapsed
                unit_req.a = {8'd0, elapsed_reg[15:0], 8'd0};
                unit_req.b = {16'd0, elapsed_reg[15:0]};
                rem_next   = unit_rsp.diff[ltpc_pkg::REM_W-1:0];
                phase_next = '0;
                cnt_next   = ltpc_pkg::DIV_TOP;
                state_next = ltpc_pkg::ST_DIV;
            end
            ltpc_pkg::ST_DIV: begin
                // one quotient bit per cycle, most significant first
                unit_req.a = {8'd0, rem_reg};
                unit_req.b = {16'd0, duration_reg} << cnt_reg;
                if (!unit_rsp.borrow) begin
                    rem_next            = unit_rsp.diff[ltpc_pkg::REM_W-1:0];
                    phase_next[cnt_reg] = 1'b1;
                end
                if (cnt_reg == '0) begin
                    cnt_next   = ltpc_pkg::CH_RED;
                    state_next = ltpc_pkg::ST_SCALE;
                end else begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ltpc_pkg::ST_SCALE: begin
                unit_req.op = ltpc_pkg::UNIT_MUL;
                unit_req.a  = {24'd0, chan_sel};
                unit_req.b  = {23'd0, weight};
                scale_we    = 1'b1;
                if (cnt_reg == ltpc_pkg::CH_BLUE) begin
                    state_next = ltpc_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ltpc_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ltpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ltpc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ltpc_pkg::ST_IDLE;
            cnt_reg        <= '0;
            start_reg      <= '0;
            color_reg      <= '0;
            m_valid_reg    <= 1'b0;
            duration_reg   <= ltpc_pkg::DURATION_RST;
            count_reg      <= ltpc_pkg::COUNT_RST;
            palette_reg[0] <= '0;
            palette_reg[1] <= '0;
            palette_reg[2] <= '0;
            palette_reg[3] <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            start_reg   <= start_next;
            color_reg   <= color_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    ltpc_pkg::REG_DURATION: duration_reg   <= cfg_data[15:0];
                    ltpc_pkg::REG_COUNT:    count_reg      <= cfg_data[2:0];
                    ltpc_pkg::REG_COLOR_0:  palette_reg[0] <= cfg_data;
                    ltpc_pkg::REG_COLOR_1:  palette_reg[1] <= cfg_data;
                    ltpc_pkg::REG_COLOR_2:  palette_reg[2] <= cfg_data;
                    ltpc_pkg::REG_COLOR_3:  palette_reg[3] <= cfg_data;
                    default: ; // drop writes beyond the register list
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        rem_reg     <= rem_next;
        phase_reg   <= phase_next;
        if (scale_we) begin
            scale_reg[cnt_reg[1:0]] <= scale_next;
        end
        if (out_load) begin
            out_red_reg   <= scale_reg[0];
            out_green_reg <= scale_reg[1];
            out_blue_reg  <= scale_reg[2];
            out_index_reg <= color_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_red     = out_red_reg;
    assign m_out_green   = out_green_reg;
    assign m_out_blue    = out_blue_reg;
    assign m_color_index = out_index_reg;
    assign m_phase       = out_phase_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a beat");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_phase != 8'hFF))
        else $error("phase out of range");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ltpc_pkg::ST_DIV && cnt_reg == '0) |=>
        (rem_reg < {8'd0, duration_reg}))
        else $error("divide left a remainder not below the duration");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ltpc_pkg::ST_DONE))
        else $error("result raised outside the load step");
`endif

endmodule
